### rtl/core/pfd_pkg.sv
// Package for the page framebuffer draw block: command codes and pixel modes.
// No dependencies; used by the channel interfaces and by the top level.
package pfd_pkg;

    typedef logic [2:0] op_code_t;
    typedef logic [1:0] mode_t;

    localparam op_code_t OP_PIXEL    = 3'd0;
    localparam op_code_t OP_BYTE_COL = 3'd1;
    localparam op_code_t OP_HLINE    = 3'd2;
    localparam op_code_t OP_VLINE    = 3'd3;
    localparam op_code_t OP_FILL     = 3'd4;
    localparam op_code_t OP_GET_PIX  = 3'd5;
    localparam op_code_t OP_READ_BYTE = 3'd6;

    localparam mode_t MODE_OFF    = 2'd0;
    localparam mode_t MODE_ON     = 2'd1;
    localparam mode_t MODE_TOGGLE = 2'd2;

    // Rows per page: one byte holds this many vertically adjacent pixels.
    localparam int unsigned PAGE_ROWS = 8;

endpackage

### rtl/core/pfd_ifs.sv
// Valid/ready channel interfaces for the page framebuffer draw block.
// Depends on pfd_pkg for the command field types.
interface pfd_cmd_if;
    logic              valid;
    logic              ready;
    pfd_pkg::op_code_t op;
    logic [7:0]        x_pos;
    logic [7:0]        y_pos;
    logic [7:0]        line_end;
    pfd_pkg::mode_t    pixel_mode;
    logic [7:0]        data_byte;

    modport source (output valid, op, x_pos, y_pos, line_end, pixel_mode, data_byte,
                    input ready);
    modport sink   (input valid, op, x_pos, y_pos, line_end, pixel_mode, data_byte,
                    output ready);
endinterface

interface pfd_res_if;
    logic       valid;
    logic       ready;
    logic       pixel_bit;
    logic [7:0] byte_value;

    modport source (output valid, pixel_bit, byte_value, input ready);
    modport sink   (input valid, pixel_bit, byte_value, output ready);
endinterface

### rtl/core/page_framebuffer_draw.sv
// Page framebuffer draw block: a sequencer around one byte-wide frame memory.
// Depends on pfd_pkg and on the pfd_cmd_if / pfd_res_if channel interfaces.
//
// The block keeps a WIDTH x HEIGHT monochrome screen in one synchronous memory of
// WIDTH * ceil(HEIGHT/8) bytes, each byte holding eight vertically adjacent pixels.
// Every command transaction on cmd produces exactly one result transaction on res.
// Commands are handled one at a time by a sequencer that reads, modifies and writes
// back one memory byte per pixel, so the memory's single read and write port set the
// rate. A single pixel command reads its byte, writes it back and then puts out the
// result; a byte column (8 pixels) or a line does the same read and write for each
// on-screen pixel and skips each off-screen pixel. Get pixel and read byte read the
// byte, wait for the registered read data and then put out the result. Fill writes
// one byte per cycle over the whole memory. After reset the same sweep clears the
// memory to zero before the first command is accepted. A finished result waits in an
// output register, and the next command is accepted while it waits. Pixels off the
// screen are skipped; get pixel or read byte of an off-screen position answers zero.
module page_framebuffer_draw #(
    parameter int unsigned WIDTH  = 128,
    parameter int unsigned HEIGHT = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    pfd_cmd_if.sink      cmd,
    pfd_res_if.source    res
);

    localparam int unsigned PAGES      = (HEIGHT + pfd_pkg::PAGE_ROWS - 1) / pfd_pkg::PAGE_ROWS;
    localparam int unsigned STORE_SIZE = WIDTH * PAGES;
    localparam int unsigned AW         = $clog2(STORE_SIZE);

    typedef enum logic [6:0] {
        ST_SWEEP    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_PIX_RD   = 7'b0000100,
        ST_PIX_WR   = 7'b0001000,
        ST_QRY_RD   = 7'b0010000,
        ST_QRY_WAIT = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    // Frame memory with registered read data.
    logic [7:0] frame_mem [STORE_SIZE];
    logic [7:0] rd_data_reg;
    logic       mem_re;
    logic       mem_we;
    logic [AW-1:0] mem_raddr;
    logic [7:0] mem_wdata;

    state_t state_reg, state_next;

    // Latched command fields.
    pfd_pkg::op_code_t op_reg, op_next;
    logic [7:0]        x_reg, x_next;
    logic [7:0]        y_reg, y_next;
    pfd_pkg::mode_t    mode_reg, mode_next;
    logic [7:0]        data_reg, data_next;
    logic [7:0]        span_reg, span_next;
    logic [7:0]        cnt_reg, cnt_next;

    // Byte address: the pixel's byte during read-modify-write, the sweep position
    // during clear and fill.
    logic [AW-1:0]     addr_reg, addr_next;
    logic [2:0]        bit_reg, bit_next;
    pfd_pkg::mode_t    pmode_reg, pmode_next;
    logic [7:0]        fill_val_reg, fill_val_next;
    logic              sweep_reply_reg, sweep_reply_next;

    // Result of the current command, and the output register.
    logic              res_bit_reg, res_bit_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_bit_reg, out_bit_next;
    logic [7:0]        out_byte_reg, out_byte_next;

    // Current pixel of the command being walked.
    logic [7:0]        px;
    logic [7:0]        py;
    logic              on_screen;
    logic [AW-1:0]     pix_addr;
    pfd_pkg::mode_t    pix_mode;
    logic [7:0]        bit_mask;
    logic [7:0]        rmw_byte;
    logic              cmd_fire;
    logic              last_pix;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[addr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= frame_mem[mem_raddr];
        end
    end

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign res.valid  = out_valid_reg;
    assign res.pixel_bit  = out_bit_reg;
    assign res.byte_value = out_byte_reg;

    // Pixel coordinates: lines step in x or y, a byte column steps in y; all mod 256.
    always_comb
    begin
        px = x_reg;
        py = y_reg;
        if (op_reg == pfd_pkg::OP_HLINE)
        begin
            px = x_reg + cnt_reg;
        end
        if (op_reg == pfd_pkg::OP_VLINE || op_reg == pfd_pkg::OP_BYTE_COL)
        begin
            py = y_reg + cnt_reg;
        end
        on_screen = ({1'b0, px} < 9'(WIDTH)) && ({1'b0, py} < 9'(HEIGHT));
        pix_addr  = AW'(32'(px) + 32'(py[7:3]) * 32'(WIDTH));
        if (op_reg == pfd_pkg::OP_BYTE_COL)
        begin
            pix_mode = data_reg[cnt_reg[2:0]] ? pfd_pkg::MODE_ON : pfd_pkg::MODE_OFF;
        end
        else
        begin
            pix_mode = mode_reg;
        end
        last_pix = (cnt_reg == span_reg);
    end

    // Modify step of the read-modify-write.
    always_comb
    begin
        bit_mask = 8'd1 << bit_reg;
        case (pmode_reg)
            pfd_pkg::MODE_ON:     rmw_byte = rd_data_reg | bit_mask;
            pfd_pkg::MODE_TOGGLE: rmw_byte = rd_data_reg ^ bit_mask;
            default:              rmw_byte = rd_data_reg & ~bit_mask;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        mode_next        = mode_reg;
        data_next        = data_reg;
        span_next        = span_reg;
        cnt_next         = cnt_reg;
        addr_next        = addr_reg;
        bit_next         = bit_reg;
        pmode_next       = pmode_reg;
        fill_val_next    = fill_val_reg;
        sweep_reply_next = sweep_reply_reg;
        res_bit_next     = res_bit_reg;
        res_byte_next    = res_byte_reg;
        out_valid_next   = out_valid_reg;
        out_bit_next     = out_bit_reg;
        out_byte_next    = out_byte_reg;
        mem_re           = 1'b0;
        mem_we           = 1'b0;
        mem_raddr        = pix_addr;
        mem_wdata        = rmw_byte;

        // The waiting result leaves when the sink takes it.
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = fill_val_reg;
                if (addr_reg == AW'(STORE_SIZE - 1))
                begin
                    state_next = sweep_reply_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next       = cmd.op;
                    x_next        = cmd.x_pos;
                    y_next        = cmd.y_pos;
                    mode_next     = cmd.pixel_mode;
                    data_next     = cmd.data_byte;
                    cnt_next      = 8'd0;
                    res_bit_next  = 1'b0;
                    res_byte_next = 8'd0;
                    span_next     = 8'd0;
                    case (cmd.op)
                        pfd_pkg::OP_HLINE:    span_next = cmd.line_end - cmd.x_pos;
                        pfd_pkg::OP_VLINE:    span_next = cmd.line_end - cmd.y_pos;
                        pfd_pkg::OP_BYTE_COL: span_next = 8'd7;
                        default:              span_next = 8'd0;
                    endcase
                    unique case (cmd.op) inside
                        pfd_pkg::OP_PIXEL, pfd_pkg::OP_BYTE_COL,
                        pfd_pkg::OP_HLINE, pfd_pkg::OP_VLINE:
                        begin
                            state_next = ST_PIX_RD;
                        end
                        pfd_pkg::OP_FILL:
                        begin
                            fill_val_next    = cmd.data_byte;
                            sweep_reply_next = 1'b1;
                            addr_next        = '0;
                            state_next       = ST_SWEEP;
                        end
                        pfd_pkg::OP_GET_PIX, pfd_pkg::OP_READ_BYTE:
                        begin
                            state_next = ST_QRY_RD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PIX_RD:
            begin
                if (on_screen)
                begin
                    mem_re     = 1'b1;
                    addr_next  = pix_addr;
                    bit_next   = py[2:0];
                    pmode_next = pix_mode;
                    state_next = ST_PIX_WR;
                end
                else if (last_pix)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end
            ST_PIX_WR:
            begin
                // The write lands before the next read, so a following pixel in the
                // same byte sees this update.
                mem_we = 1'b1;
                if (last_pix)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 8'd1;
                    state_next = ST_PIX_RD;
                end
            end
            ST_QRY_RD:
            begin
                if (on_screen)
                begin
                    mem_re     = 1'b1;
                    bit_next   = py[2:0];
                    state_next = ST_QRY_WAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_QRY_WAIT:
            begin
                if (op_reg == pfd_pkg::OP_GET_PIX)
                begin
                    res_bit_next = rd_data_reg[bit_reg];
                end
                else
                begin
                    res_byte_next = rd_data_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_bit_next     = res_bit_reg;
                    out_byte_next    = res_byte_reg;
                    sweep_reply_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Reset starts with a clearing sweep of the whole memory.
            state_reg       <= ST_SWEEP;
            addr_reg        <= '0;
            fill_val_reg    <= 8'd0;
            sweep_reply_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            fill_val_reg    <= fill_val_next;
            sweep_reply_reg <= sweep_reply_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        mode_reg     <= mode_next;
        data_reg     <= data_next;
        span_reg     <= span_next;
        cnt_reg      <= cnt_next;
        bit_reg      <= bit_next;
        pmode_reg    <= pmode_next;
        res_bit_reg  <= res_bit_next;
        res_byte_reg <= res_byte_next;
        out_bit_reg  <= out_bit_next;
        out_byte_reg <= out_byte_next;
    end

endmodule

### tb/page_framebuffer_draw_checker.sv
`timescale 1ns / 1ps
// Checker for page_framebuffer_draw: keeps its own copy of the frame memory and works out
// the answer to every accepted command, then compares each result transaction with it.
// Depends on pfd_pkg and on the pfd_cmd_if / pfd_res_if channel interfaces.
module page_framebuffer_draw_checker #(
    parameter int unsigned WIDTH  = 128,
    parameter int unsigned HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    pfd_cmd_if          cmd,
    pfd_res_if          res,
    output int unsigned mismatches,
    output int unsigned pending
);

    localparam int unsigned PAGES       = (HEIGHT + pfd_pkg::PAGE_ROWS - 1) / pfd_pkg::PAGE_ROWS;
    localparam int unsigned STORE_BYTES = WIDTH * PAGES;

    typedef struct packed {
        logic       pixel_bit;
        logic [7:0] byte_value;
    } draw_answer_t;

    logic [7:0]   screen_bytes [STORE_BYTES];
    draw_answer_t answers_due [$];
    draw_answer_t oldest;

    function automatic bit visible(input logic [7:0] px, input logic [7:0] py);
        return (px < WIDTH) && (py < HEIGHT);
    endfunction

    function automatic int unsigned byte_index(input logic [7:0] px, input logic [7:0] py);
        return px + (py / pfd_pkg::PAGE_ROWS) * WIDTH;
    endfunction

    function automatic void plot(input logic [7:0] px, input logic [7:0] py,
                                 input pfd_pkg::mode_t mode);
        int unsigned idx;
        logic [7:0]  mask;
        if (!visible(px, py))
        begin
            return;
        end
        idx  = byte_index(px, py);
        mask = 8'd1 << py[2:0];
        case (mode)
            pfd_pkg::MODE_ON:     screen_bytes[idx] = screen_bytes[idx] | mask;
            pfd_pkg::MODE_TOGGLE: screen_bytes[idx] = screen_bytes[idx] ^ mask;
            default:              screen_bytes[idx] = screen_bytes[idx] & ~mask;
        endcase
    endfunction

    // Applies one command to the local frame copy and returns the answer it must produce.
    function automatic draw_answer_t run_command(input pfd_pkg::op_code_t op,
                                                 input logic [7:0] x,
                                                 input logic [7:0] y,
                                                 input logic [7:0] line_end,
                                                 input pfd_pkg::mode_t mode,
                                                 input logic [7:0] data);
        draw_answer_t answer;
        logic [7:0]   span;
        int unsigned  k;
        answer = '0;
        case (op)
            pfd_pkg::OP_PIXEL:
                plot(x, y, mode);
            pfd_pkg::OP_BYTE_COL:
                for (k = 0; k < pfd_pkg::PAGE_ROWS; k++)
                begin
                    plot(x, 8'(y + k), data[k] ? pfd_pkg::MODE_ON : pfd_pkg::MODE_OFF);
                end
            pfd_pkg::OP_HLINE:
            begin
                span = line_end - x;
                for (k = 0; k <= span; k++)
                begin
                    plot(8'(x + k), y, mode);
                end
            end
            pfd_pkg::OP_VLINE:
            begin
                span = line_end - y;
                for (k = 0; k <= span; k++)
                begin
                    plot(x, 8'(y + k), mode);
                end
            end
            pfd_pkg::OP_FILL:
                foreach (screen_bytes[a])
                begin
                    screen_bytes[a] = data;
                end
            pfd_pkg::OP_GET_PIX:
                if (visible(x, y))
                begin
                    answer.pixel_bit = screen_bytes[byte_index(x, y)][y[2:0]];
                end
            pfd_pkg::OP_READ_BYTE:
                if (visible(x, y))
                begin
                    answer.byte_value = screen_bytes[byte_index(x, y)];
                end
            default:
                ;
        endcase
        return answer;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
    endtask

    // Results are handled before commands so that a result and a command accepted
    // at the same edge never meet an empty store by accident.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (screen_bytes[a])
            begin
                screen_bytes[a] = 8'h00;
            end
            answers_due.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    report_mismatch("result with no command outstanding", res.byte_value, 0);
                end
                else
                begin
                    oldest = answers_due.pop_front();
                    if (res.pixel_bit !== oldest.pixel_bit)
                    begin
                        report_mismatch("pixel_bit", res.pixel_bit, oldest.pixel_bit);
                    end
                    if (res.byte_value !== oldest.byte_value)
                    begin
                        report_mismatch("byte_value", res.byte_value, oldest.byte_value);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                answers_due.push_back(run_command(cmd.op, cmd.x_pos, cmd.y_pos, cmd.line_end,
                                                  cmd.pixel_mode, cmd.data_byte));
            end
            pending <= answers_due.size();
        end
    end

endmodule

### tb/page_framebuffer_draw_tb.sv
`timescale 1ns / 1ps
// Top of the page_framebuffer_draw testbench: clock, reset, command stimulus, result
// back-pressure and the verdict. Depends on pfd_pkg, the channel interfaces, the block
// and page_framebuffer_draw_checker, which does all prediction and comparison.
module page_framebuffer_draw_tb;

    localparam int unsigned WIDTH        = 128;
    localparam int unsigned HEIGHT       = 64;
    localparam int unsigned CLK_PERIOD   = 4;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned RANDOM_ITEMS = 1275;
    // Longest correct gap between transactions is the clearing sweep after reset or a
    // fill overlapping a long receiver hold-off; allow several times that.
    localparam int unsigned QUIET_LIMIT  = 6000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned IDLE_PCT     = 34;

    // The package names no code for the spare opcode or for the second "off" mode.
    localparam pfd_pkg::op_code_t OP_UNUSED    = 3'd7;
    localparam pfd_pkg::mode_t    MODE_OFF_ALT = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pfd_cmd_if cmd_ch ();
    pfd_res_if res_ch ();

    int unsigned mismatches;
    int unsigned pending;

    // Idle rates of the two sides; the stimulus drops both to zero for a while.
    int unsigned cmd_idle_pct  = IDLE_PCT;
    int unsigned res_idle_pct  = IDLE_PCT;
    // The stimulus raises hold_requests; the receiver answers each with one long hold-off.
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned quiet_cycles  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    page_framebuffer_draw #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    page_framebuffer_draw_checker #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Offers one command and returns at the edge where it is accepted. Any idle gap is
    // taken in front of the command, so valid only ever drops right after an acceptance
    // and is never lowered and raised again within one time step.
    task automatic send_command(input pfd_pkg::op_code_t op, input logic [7:0] x,
                                input logic [7:0] y, input logic [7:0] line_end,
                                input pfd_pkg::mode_t mode, input logic [7:0] data);
        if ($urandom_range(0, 99) < cmd_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < cmd_idle_pct);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.x_pos      <= x;
        cmd_ch.y_pos      <= y;
        cmd_ch.line_end   <= line_end;
        cmd_ch.pixel_mode <= mode;
        cmd_ch.data_byte  <= data;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Random command. Coordinates mostly land on the screen so that drawing and reading
    // back meet in the same bytes; a share goes anywhere in the 8-bit range to exercise
    // the off-screen paths. Lines are mostly short, since the block walks them pixel by
    // pixel, and a fill, which sweeps the whole memory, is rare.
    task automatic send_random_command();
        pfd_pkg::op_code_t op;
        logic [7:0]        x;
        logic [7:0]        y;
        logic [7:0]        line_end;
        logic [7:0]        start;
        int unsigned       pick;
        int unsigned       axis;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            op = pfd_pkg::OP_PIXEL;
        else if (pick < 32)
            op = pfd_pkg::OP_BYTE_COL;
        else if (pick < 42)
            op = pfd_pkg::OP_HLINE;
        else if (pick < 52)
            op = pfd_pkg::OP_VLINE;
        else if (pick < 53)
            op = pfd_pkg::OP_FILL;
        else if (pick < 73)
            op = pfd_pkg::OP_GET_PIX;
        else if (pick < 96)
            op = pfd_pkg::OP_READ_BYTE;
        else
            op = OP_UNUSED;
        x = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, WIDTH - 1)) : 8'($urandom);
        y = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, HEIGHT - 1)) : 8'($urandom);
        start = (op == pfd_pkg::OP_VLINE) ? y : x;
        axis  = (op == pfd_pkg::OP_VLINE) ? HEIGHT : WIDTH;
        pick  = $urandom_range(0, 99);
        if (pick < 75)
            line_end = 8'(start + $urandom_range(0, 15));
        else if (pick < 90)
            line_end = 8'($urandom_range(0, axis - 1));
        else
            line_end = 8'($urandom);
        send_command(op, x, y, line_end, pfd_pkg::mode_t'($urandom), 8'($urandom));
    endtask

    // Receiver: random back-pressure on the result channel, plus one long hold-off per
    // request. The hold-off is counted here so the sender keeps offering commands
    // meanwhile, which fills the block's output register and stalls its command input.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 99) >= res_idle_pct);
            end
        end
    end

    // Watchdog: a hung handshake on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** page_framebuffer_draw: FAILED **");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int unsigned item;

        cmd_ch.valid      <= 1'b0;
        cmd_ch.op         <= pfd_pkg::OP_PIXEL;
        cmd_ch.x_pos      <= 8'h00;
        cmd_ch.y_pos      <= 8'h00;
        cmd_ch.line_end   <= 8'h00;
        cmd_ch.pixel_mode <= pfd_pkg::MODE_OFF;
        cmd_ch.data_byte  <= 8'h00;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block clears its memory after reset, so the first read
        // must see zero. Then the screen corners, pixels just off the right and bottom
        // edges, every pixel mode including the spare code that acts as off, byte
        // columns that run off the bottom and wrap past row 255, lines that wrap past
        // coordinate 255, a full 256-pixel line and a one-pixel line, reads of
        // off-screen positions, fills with both extreme patterns and the unused opcode.
        send_command(pfd_pkg::OP_GET_PIX,   8'd0, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(pfd_pkg::OP_PIXEL,     8'd0, 8'd0, 8'd0, pfd_pkg::MODE_ON, 8'h00);
        send_command(pfd_pkg::OP_GET_PIX,   8'd0, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(pfd_pkg::OP_PIXEL,     8'd127, 8'd63, 8'd0, pfd_pkg::MODE_ON, 8'h00);
        send_command(pfd_pkg::OP_READ_BYTE, 8'd127, 8'd63, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(pfd_pkg::OP_PIXEL,     8'd128, 8'd0, 8'd0, pfd_pkg::MODE_ON, 8'h00);
        send_command(pfd_pkg::OP_PIXEL,     8'd0, 8'd64, 8'd0, pfd_pkg::MODE_TOGGLE, 8'h00);
        send_command(pfd_pkg::OP_GET_PIX,   8'd255, 8'd255, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(pfd_pkg::OP_READ_BYTE, 8'd128, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(pfd_pkg::OP_PIXEL,     8'd0, 8'd0, 8'd0, pfd_pkg::MODE_TOGGLE, 8'h00);
        send_command(pfd_pkg::OP_PIXEL,     8'd127, 8'd63, 8'd0, MODE_OFF_ALT, 8'h00);
        send_command(pfd_pkg::OP_BYTE_COL,  8'd5, 8'd60, 8'd0, pfd_pkg::MODE_OFF, 8'hA5);
        send_command(pfd_pkg::OP_BYTE_COL,  8'd9, 8'd252, 8'd0, pfd_pkg::MODE_OFF, 8'hFF);
        send_command(pfd_pkg::OP_BYTE_COL,  8'd255, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'hFF);
        send_command(pfd_pkg::OP_READ_BYTE, 8'd9, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(pfd_pkg::OP_HLINE,     8'd120, 8'd10, 8'd3, pfd_pkg::MODE_ON, 8'h00);
        send_command(pfd_pkg::OP_HLINE,     8'd0, 8'd63, 8'd255, pfd_pkg::MODE_TOGGLE, 8'h00);
        send_command(pfd_pkg::OP_HLINE,     8'd40, 8'd20, 8'd40, pfd_pkg::MODE_ON, 8'h00);
        send_command(pfd_pkg::OP_VLINE,     8'd7, 8'd60, 8'd2, pfd_pkg::MODE_TOGGLE, 8'h00);
        send_command(pfd_pkg::OP_VLINE,     8'd127, 8'd0, 8'd63, pfd_pkg::MODE_ON, 8'h00);
        send_command(pfd_pkg::OP_READ_BYTE, 8'd7, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(pfd_pkg::OP_FILL,      8'd0, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'hFF);
        send_command(pfd_pkg::OP_READ_BYTE, 8'd64, 8'd63, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(pfd_pkg::OP_GET_PIX,   8'd255, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'h00);
        send_command(OP_UNUSED,             8'd255, 8'd255, 8'd255, MODE_OFF_ALT, 8'hFF);
        send_command(pfd_pkg::OP_FILL,      8'd0, 8'd0, 8'd0, pfd_pkg::MODE_OFF, 8'h00);

        // Random part, with a stretch where neither side idles, two long receiver
        // hold-offs (one inside that stretch) and one point where the sender stops
        // until every outstanding result has come back.
        for (item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (item == 200)
            begin
                cmd_idle_pct = 0;
                res_idle_pct = 0;
            end
            if (item == 450)
            begin
                cmd_idle_pct = IDLE_PCT;
                res_idle_pct = IDLE_PCT;
            end
            if (item == 300 || item == 700)
            begin
                hold_requests++;
            end
            if (item == 800)
            begin
                cmd_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            send_random_command();
        end

        // Drain: wait for every expected result, then a few cycles for any stray one.
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
        begin
            $display("** page_framebuffer_draw: PASSED **");
        end
        else
        begin
            $display("** page_framebuffer_draw: FAILED **");
        end
        $finish;
    end

endmodule
